// ===== rtl/lane_steering_heading_core_macros.svh =====
// Assertion macros for the lane steering heading core.
// Both forms sample on clk and stand down while rst_n is low.
`ifndef LANE_STEERING_HEADING_CORE_MACROS_SVH
`define LANE_STEERING_HEADING_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define LSH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lane steering heading check failed");
`define LSH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lane steering heading check failed");
`else
`define LSH_ASSERT(lbl, prop)
`define LSH_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ===== rtl/lsh_pkg.sv =====
package lsh_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int CW                = 48;  // CORDIC x/y width
  localparam int ZW                = 25;  // angle width, Q16 degrees
  localparam int SQW               = 34;  // square root working width

  localparam logic signed [ZW-1:0] DEG90_Q16   = 25'sd5898240;
  localparam logic [14:0]          HEADING_MAX = 15'd23040;
  localparam logic [22:0]          PULSE_DEN   = 23'd6943054;
  localparam logic [33:0]          PULSE_HALF  = 34'd3471527;
  localparam logic [18:0]          PULSE_GAIN  = 19'd500000;
  // floor(2^24 * 500000 / PULSE_DEN); the estimate it gives is low by at most one.
  localparam logic [20:0]          PULSE_RECIP = 21'd1208201;
  // One half in the 2^24 scale of the estimate.
  localparam logic [34:0]          PULSE_RND   = 35'd8388608;

  typedef enum logic [2:0] {
    CFG_OUTLIER_THRESHOLD = 3'd0,
    CFG_SENSOR_SPACING    = 3'd1,
    CFG_LATERAL_GAIN      = 3'd2,
    CFG_MIN_SPEED         = 3'd3,
    CFG_HEADING_LIMIT     = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SIDE_CORDIC = 2'd0,
    SIDE_ZERO   = 2'd1,
    SIDE_POS90  = 2'd2,
    SIDE_NEG90  = 2'd3
  } side_kind_t;

  typedef struct packed {
    side_kind_t kind;
    logic       neg;
  } side_t;

  typedef struct packed {
    logic [41:0] num;
    logic [38:0] xden;
    logic        neg;
    logic        zero;
  } atan_in_t;

  // Arctangent of 2^-i in degrees, Q16.
  function automatic logic signed [ZW-1:0] atan_deg_q16(input logic [4:0] idx);
    logic signed [ZW-1:0] a;
    begin
      case (idx)
        5'd0:  a = 25'sd2949120;
        5'd1:  a = 25'sd1740967;
        5'd2:  a = 25'sd919879;
        5'd3:  a = 25'sd466945;
        5'd4:  a = 25'sd234379;
        5'd5:  a = 25'sd117304;
        5'd6:  a = 25'sd58666;
        5'd7:  a = 25'sd29335;
        5'd8:  a = 25'sd14668;
        5'd9:  a = 25'sd7334;
        5'd10: a = 25'sd3667;
        5'd11: a = 25'sd1833;
        5'd12: a = 25'sd917;
        5'd13: a = 25'sd458;
        5'd14: a = 25'sd229;
        5'd15: a = 25'sd115;
        5'd16: a = 25'sd57;
        5'd17: a = 25'sd29;
        5'd18: a = 25'sd14;
        5'd19: a = 25'sd7;
        5'd20: a = 25'sd4;
        5'd21: a = 25'sd2;
        5'd22: a = 25'sd1;
        default: a = '0;
      endcase
      return a;
    end
  endfunction

endpackage

// ===== rtl/lsh_div_cell.sv =====
// One restoring division step: brings in the next dividend bit and
// emits one quotient bit.
module lsh_div_cell #(
  parameter int DW = 16,
  parameter int LW = 17,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic [DW-1:0] rem_i,
  input  logic [LW-1:0] low_i,
  input  logic [QW-1:0] q_i,
  input  logic [DW-1:0] den_i,
  output logic [DW-1:0] rem_o,
  output logic [LW-1:0] low_o,
  output logic [QW-1:0] q_o
);

  logic [DW:0]   wide;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_nxt;
  logic [DW-1:0] rem_r;
  logic [LW-1:0] low_r;
  logic [QW-1:0] q_r;

  always_comb begin
    wide    = {rem_i, low_i[LW-1]};
    diff    = wide - {1'b0, den_i};
    ge      = (wide >= {1'b0, den_i});
    rem_nxt = ge ? diff[DW-1:0] : wide[DW-1:0];
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    low_r <= {low_i[LW-2:0], 1'b0};
    q_r   <= {q_i[QW-2:0], ge};
  end

  assign rem_o = rem_r;
  assign low_o = low_r;
  assign q_o   = q_r;

endmodule

// ===== rtl/lsh_sqrt_cell.sv =====
// One step of the bit-pair integer square root, for result bit K.
module lsh_sqrt_cell #(
  parameter int K = 16
) (
  input  logic                   clk,
  input  logic [lsh_pkg::SQW-1:0] v_i,
  input  logic [lsh_pkg::SQW-1:0] res_i,
  output logic [lsh_pkg::SQW-1:0] v_o,
  output logic [lsh_pkg::SQW-1:0] res_o
);

  localparam logic [lsh_pkg::SQW-1:0] BITV = lsh_pkg::SQW'(1) << (2 * K);

  logic [lsh_pkg::SQW-1:0] sum;
  logic                    ge;
  logic [lsh_pkg::SQW-1:0] v_r;
  logic [lsh_pkg::SQW-1:0] res_r;

  always_comb begin
    sum = res_i + BITV;
    ge  = (v_i >= sum);
  end

  always_ff @(posedge clk) begin
    v_r   <= ge ? (v_i - sum) : v_i;
    res_r <= ge ? ((res_i >> 1) + BITV) : (res_i >> 1);
  end

  assign v_o   = v_r;
  assign res_o = res_r;

endmodule

// ===== rtl/lsh_cordic_cell.sv =====
// One CORDIC vectoring step with floor shifts, driving y toward zero.
module lsh_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic                         clk,
  input  logic signed [lsh_pkg::CW-1:0] x_i,
  input  logic signed [lsh_pkg::CW-1:0] y_i,
  input  logic signed [lsh_pkg::ZW-1:0] z_i,
  output logic signed [lsh_pkg::CW-1:0] x_o,
  output logic signed [lsh_pkg::CW-1:0] y_o,
  output logic signed [lsh_pkg::ZW-1:0] z_o
);

  logic signed [lsh_pkg::CW-1:0] xs;
  logic signed [lsh_pkg::CW-1:0] ys;
  logic signed [lsh_pkg::ZW-1:0] ang;
  logic signed [lsh_pkg::CW-1:0] x_r;
  logic signed [lsh_pkg::CW-1:0] y_r;
  logic signed [lsh_pkg::ZW-1:0] z_r;

  always_comb begin
    xs  = x_i >>> IDX;
    ys  = y_i >>> IDX;
    ang = lsh_pkg::atan_deg_q16(5'(IDX));
  end

  always_ff @(posedge clk) begin
    if (!y_i[lsh_pkg::CW-1]) begin
      x_r <= x_i + ys;
      y_r <= y_i - xs;
      z_r <= z_i + ang;
    end else begin
      x_r <= x_i - ys;
      y_r <= y_i + xs;
      z_r <= z_i - ang;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

// ===== rtl/lane_steering_heading_core.sv =====
// Channel  | Ports                                   | Transfer rule
// ---------+-----------------------------------------+-------------------------------
// input    | start, busy, in_* distances and speed   | start high while busy is low
// result   | out_valid, out_heading_deg, out_pulse.. | out_valid high for one cycle
// config   | cfg_we, cfg_index, cfg_data             | cfg_we high, no wait
//
// One reading set is taken in every cycle; busy is always low.
// An input transfer reaches its result through the 17-step divider chain,
// the 17-step square root chain, the CORDIC chain and three stages of
// reciprocal pulse scaling.
// rst_n is synchronous, clears the valid chain and resets the configuration registers.
// The receiver cannot stall, so results leave the pipeline as they finish.
`include "lane_steering_heading_core_macros.svh"

module lane_steering_heading_core #(
  parameter int CORDIC_STAGES = lsh_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_left_outer_dist,
  input  logic [15:0] in_left_inner_dist,
  input  logic [15:0] in_right_inner_dist,
  input  logic [15:0] in_right_outer_dist,
  input  logic signed [15:0] in_speed_mm_s,
  output logic        out_valid,
  output logic signed [15:0] out_heading_deg,
  output logic [10:0] out_pulse_width_us,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int C      = CORDIC_STAGES;
  localparam int VLAT   = 42 + C;
  localparam int SDLEN  = 35 + C;
  localparam int ATLEN  = 33;
  localparam int CW     = lsh_pkg::CW;
  localparam int ZW     = lsh_pkg::ZW;
  localparam int SQW    = lsh_pkg::SQW;

  // Configuration registers.
  logic [15:0] thr_r;
  logic [15:0] spacing_r;
  logic [15:0] gain_r;
  logic [14:0] min_speed_r;
  logic [14:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= 16'd2253;
      spacing_r   <= 16'd1229;
      gain_r      <= 16'd8192;
      min_speed_r <= 15'd1;
      limit_r     <= 15'd6943;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lsh_pkg::CFG_OUTLIER_THRESHOLD: thr_r       <= cfg_data;
        lsh_pkg::CFG_SENSOR_SPACING:    spacing_r   <= cfg_data;
        lsh_pkg::CFG_LATERAL_GAIN:      gain_r      <= cfg_data;
        lsh_pkg::CFG_MIN_SPEED:         min_speed_r <= cfg_data[14:0];
        lsh_pkg::CFG_HEADING_LIMIT:     limit_r     <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // The pipeline never pushes back.
  assign busy = 1'b0;

  logic [VLAT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[VLAT-2:0], start & ~busy};
    end
  end

  // Classify one side's difference against the sensor spacing. Differences
  // beyond the spacing pin to ninety degrees; a zero difference gives zero.
  function automatic lsh_pkg::side_t side_class(input logic signed [16:0] d,
                                                input logic [15:0] s);
    logic signed [17:0] de;
    logic signed [17:0] se;
    lsh_pkg::side_t     sd;
    begin
      de     = {d[16], d};
      se     = $signed({2'b00, s});
      sd.neg = d[16];
      if (de > se) begin
        sd.kind = lsh_pkg::SIDE_POS90;
      end else if (de < -se) begin
        sd.kind = lsh_pkg::SIDE_NEG90;
      end else if (d == 17'sd0) begin
        sd.kind = lsh_pkg::SIDE_ZERO;
      end else begin
        sd.kind = lsh_pkg::SIDE_CORDIC;
      end
      return sd;
    end
  endfunction

  // Stage A: outlier replacement, side differences, lateral error and the
  // speed choice.
  logic [15:0]        lo_adj;
  logic [15:0]        ro_adj;
  logic signed [16:0] d_side [2];
  logic [16:0]        d_abs [2];
  logic signed [16:0] lat;
  logic [16:0]        lat_abs;
  logic               spd_use;

  always_comb begin
    lo_adj = (in_left_outer_dist > thr_r) ? in_right_outer_dist : in_left_outer_dist;
    ro_adj = (in_right_outer_dist > thr_r) ? lo_adj : in_right_outer_dist;
    d_side[0] = $signed({1'b0, lo_adj}) - $signed({1'b0, in_left_inner_dist});
    d_side[1] = $signed({1'b0, ro_adj}) - $signed({1'b0, in_right_inner_dist});
    for (int s = 0; s < 2; s++) begin
      d_abs[s] = d_side[s][16] ? 17'(-d_side[s]) : 17'(d_side[s]);
    end
    lat     = $signed({1'b0, in_right_inner_dist}) - $signed({1'b0, in_left_inner_dist});
    lat_abs = lat[16] ? 17'(-lat) : 17'(lat);
    spd_use = (in_speed_mm_s >= $signed({1'b0, min_speed_r}));
  end

  lsh_pkg::side_t a_side_r [2];
  logic [15:0]    a_mag_r [2];
  logic [15:0]    a_latmag_r;
  logic           a_latneg_r;
  logic [14:0]    a_vsel_r;

  always_ff @(posedge clk) begin
    for (int s = 0; s < 2; s++) begin
      a_side_r[s] <= side_class(d_side[s], spacing_r);
      a_mag_r[s]  <= d_abs[s][15:0];
    end
    a_latmag_r <= lat_abs[15:0];
    a_latneg_r <= lat[16];
    a_vsel_r   <= spd_use ? in_speed_mm_s[14:0] : 15'd2000;
  end

  // Lateral term: gain times error, then times 1000, one multiply per stage.
  logic [31:0]        m1_prod_r;
  logic [14:0]        m1_vsel_r;
  logic               m1_latneg_r;
  lsh_pkg::atan_in_t  m2_r;
  lsh_pkg::atan_in_t  at_dly_r [ATLEN];
  logic [1:0]         flg_dly_r [C];

  always_ff @(posedge clk) begin
    m1_prod_r   <= 32'(gain_r) * 32'(a_latmag_r);
    m1_vsel_r   <= a_vsel_r;
    m1_latneg_r <= a_latneg_r;
    m2_r.num    <= 42'(m1_prod_r) * 42'd1000;
    m2_r.xden   <= {m1_vsel_r, 24'd0};
    m2_r.neg    <= m1_latneg_r;
    m2_r.zero   <= (m1_prod_r == 32'd0);
    at_dly_r[0] <= m2_r;
    for (int i = 1; i < ATLEN; i++) begin
      at_dly_r[i] <= at_dly_r[i-1];
    end
    flg_dly_r[0] <= {at_dly_r[ATLEN-1].neg, at_dly_r[ATLEN-1].zero};
    for (int i = 1; i < C; i++) begin
      flg_dly_r[i] <= flg_dly_r[i-1];
    end
  end

  // Side codes wait alongside the divider, root and CORDIC chains.
  lsh_pkg::side_t side_dly_r [2][SDLEN];

  always_ff @(posedge clk) begin
    for (int s = 0; s < 2; s++) begin
      side_dly_r[s][0] <= a_side_r[s];
      for (int i = 1; i < SDLEN; i++) begin
        side_dly_r[s][i] <= side_dly_r[s][i-1];
      end
    end
  end

  // Sine ratio r = mag * 2^16 / spacing, one quotient bit per cell.
  logic [15:0] dv_rem [2][18];
  logic [16:0] dv_low [2][18];
  logic [16:0] dv_q   [2][18];

  // Square root input and chain.
  logic [SQW-1:0] v_r   [2];
  logic [16:0]    r_dly_r [2][18];
  logic [SQW-1:0] sq_v   [2][18];
  logic [SQW-1:0] sq_res [2][18];

  // CORDIC chains: left, right, lateral.
  logic signed [CW-1:0] cx [3][C+1];
  logic signed [CW-1:0] cy [3][C+1];
  logic signed [ZW-1:0] cz [3][C+1];

  for (genvar s = 0; s < 2; s++) begin : g_side
    assign dv_rem[s][0] = {1'b0, a_mag_r[s][15:1]};
    assign dv_low[s][0] = {a_mag_r[s][0], 16'd0};
    assign dv_q[s][0]   = '0;

    for (genvar k = 0; k < 17; k++) begin : g_div
      lsh_div_cell #(.DW(16), .LW(17), .QW(17)) u_div (
        .clk   (clk),
        .rem_i (dv_rem[s][k]),
        .low_i (dv_low[s][k]),
        .q_i   (dv_q[s][k]),
        .den_i (spacing_r),
        .rem_o (dv_rem[s][k+1]),
        .low_o (dv_low[s][k+1]),
        .q_o   (dv_q[s][k+1])
      );
    end

    always_ff @(posedge clk) begin
      v_r[s]        <= (SQW'(1) << 32) - (SQW'(dv_q[s][17]) * SQW'(dv_q[s][17]));
      r_dly_r[s][0] <= dv_q[s][17];
      for (int i = 1; i < 18; i++) begin
        r_dly_r[s][i] <= r_dly_r[s][i-1];
      end
    end

    assign sq_v[s][0]   = v_r[s];
    assign sq_res[s][0] = '0;

    for (genvar k = 0; k < 17; k++) begin : g_sqrt
      lsh_sqrt_cell #(.K(16 - k)) u_sqrt (
        .clk   (clk),
        .v_i   (sq_v[s][k]),
        .res_i (sq_res[s][k]),
        .v_o   (sq_v[s][k+1]),
        .res_o (sq_res[s][k+1])
      );
    end

    // asin as the angle of (cos, sin), both scaled by 2^30.
    assign cx[s][0] = $signed(CW'({sq_res[s][17][16:0], 14'd0}));
    assign cy[s][0] = $signed(CW'({r_dly_r[s][17], 14'd0}));
    assign cz[s][0] = '0;
  end

  assign cx[2][0] = $signed(CW'(at_dly_r[ATLEN-1].xden));
  assign cy[2][0] = $signed(CW'(at_dly_r[ATLEN-1].num));
  assign cz[2][0] = '0;

  for (genvar u = 0; u < 3; u++) begin : g_cordic
    for (genvar g = 0; g < C; g++) begin : g_step
      lsh_cordic_cell #(.IDX(g)) u_cordic (
        .clk (clk),
        .x_i (cx[u][g]),
        .y_i (cy[u][g]),
        .z_i (cz[u][g]),
        .x_o (cx[u][g+1]),
        .y_o (cy[u][g+1]),
        .z_o (cz[u][g+1])
      );
    end
  end

  function automatic logic signed [ZW-1:0] clamp_z(input logic signed [ZW-1:0] z);
    begin
      if (z < 0) begin
        return '0;
      end else if (z > lsh_pkg::DEG90_Q16) begin
        return lsh_pkg::DEG90_Q16;
      end
      return z;
    end
  endfunction

  function automatic logic signed [ZW-1:0] side_val(input lsh_pkg::side_t sd,
                                                    input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] zc;
    begin
      zc = clamp_z(z);
      unique case (sd.kind)
        lsh_pkg::SIDE_POS90:  return lsh_pkg::DEG90_Q16;
        lsh_pkg::SIDE_NEG90:  return -lsh_pkg::DEG90_Q16;
        lsh_pkg::SIDE_ZERO:   return '0;
        lsh_pkg::SIDE_CORDIC: return sd.neg ? -zc : zc;
      endcase
    end
  endfunction

  // F1: signed side angles and lateral term. The right side counts negated.
  logic signed [ZW-1:0] sv_l;
  logic signed [ZW-1:0] sv_r;
  logic signed [ZW-1:0] za;
  logic signed [25:0]   f1_lr_r;
  logic signed [ZW-1:0] f1_at_r;

  always_comb begin
    sv_l = side_val(side_dly_r[0][SDLEN-1], cz[0][C]);
    sv_r = side_val(side_dly_r[1][SDLEN-1], cz[1][C]);
    za   = clamp_z(cz[2][C]);
  end

  always_ff @(posedge clk) begin
    f1_lr_r <= $signed({sv_l[ZW-1], sv_l}) - $signed({sv_r[ZW-1], sv_r});
    if (flg_dly_r[C-1][0]) begin
      f1_at_r <= '0;
    end else begin
      f1_at_r <= flg_dly_r[C-1][1] ? -za : za;
    end
  end

  // F2: mean, sum, rounding to Q8.8 and saturation.
  logic signed [25:0] half;
  logic signed [26:0] dsum;
  logic signed [26:0] hfull;
  logic [14:0]        lim;
  logic signed [26:0] lim27;
  logic signed [15:0] lim16;
  logic signed [15:0] f2_hq_r;

  always_comb begin
    half  = f1_lr_r >>> 1;
    dsum  = $signed({half[25], half}) + $signed({{2{f1_at_r[ZW-1]}}, f1_at_r}) + 27'sd128;
    hfull = dsum >>> 8;
    lim   = (limit_r > lsh_pkg::HEADING_MAX) ? lsh_pkg::HEADING_MAX : limit_r;
    lim27 = $signed({12'd0, lim});
    lim16 = $signed({1'b0, lim});
  end

  always_ff @(posedge clk) begin
    if (hfull > lim27) begin
      f2_hq_r <= lim16;
    end else if (hfull < -lim27) begin
      f2_hq_r <= -lim16;
    end else begin
      f2_hq_r <= hfull[15:0];
    end
  end

  // P1: pulse numerator |hq| * 500000 plus half the divisor, and a quotient
  // estimate from a reciprocal multiply that is never high and at most one low.
  logic [15:0]        habs;
  logic [33:0]        p1_t_r;
  logic [34:0]        p1_e_r;
  logic signed [15:0] p1_hq_r;

  always_comb begin
    habs = f2_hq_r[15] ? 16'(-f2_hq_r) : 16'(f2_hq_r);
  end

  always_ff @(posedge clk) begin
    p1_t_r  <= 34'(habs) * 34'(lsh_pkg::PULSE_GAIN) + lsh_pkg::PULSE_HALF;
    p1_e_r  <= 35'(habs) * 35'(lsh_pkg::PULSE_RECIP) + lsh_pkg::PULSE_RND;
    p1_hq_r <= f2_hq_r;
  end

  // P2: the estimate and its product with the divisor.
  logic [10:0]        p2_q0_r;
  logic [33:0]        p2_qd_r;
  logic [33:0]        p2_t_r;
  logic signed [15:0] p2_hq_r;

  always_ff @(posedge clk) begin
    p2_q0_r <= p1_e_r[34:24];
    p2_qd_r <= 34'(p1_e_r[34:24]) * 34'(lsh_pkg::PULSE_DEN);
    p2_t_r  <= p1_t_r;
    p2_hq_r <= p1_hq_r;
  end

  // P3: a remainder of one divisor or more means the estimate was one low.
  logic [33:0]        p_rem;
  logic [10:0]        p3_q_r;
  logic signed [15:0] p3_hq_r;

  always_comb begin
    p_rem = p2_t_r - p2_qd_r;
  end

  always_ff @(posedge clk) begin
    p3_q_r  <= (p_rem >= 34'(lsh_pkg::PULSE_DEN)) ? (p2_q0_r + 11'd1) : p2_q0_r;
    p3_hq_r <= p2_hq_r;
  end

  // Output register: pulse centered on 1500 and clamped to the servo range.
  logic signed [12:0] q13;
  logic signed [12:0] pls;
  logic [10:0]        pls_c;
  logic signed [15:0] heading_r;
  logic [10:0]        pulse_r;

  always_comb begin
    q13 = $signed({2'b00, p3_q_r});
    pls = p3_hq_r[15] ? (13'sd1500 - q13) : (13'sd1500 + q13);
    if (pls < 13'sd1000) begin
      pls_c = 11'd1000;
    end else if (pls > 13'sd2000) begin
      pls_c = 11'd2000;
    end else begin
      pls_c = pls[10:0];
    end
  end

  always_ff @(posedge clk) begin
    heading_r <= p3_hq_r;
    pulse_r   <= pls_c;
  end

  assign out_valid          = vld_r[VLAT-1];
  assign out_heading_deg    = heading_r;
  assign out_pulse_width_us = pulse_r;

  // Every input transfer produces exactly one result after the fixed latency.
  `LSH_ASSERT(a_latency, start |-> ##VLAT out_valid)
  `LSH_ASSERT_IMP(a_origin, out_valid, $past(start, VLAT))
  `LSH_ASSERT_IMP(a_pulse_range, out_valid, (out_pulse_width_us >= 11'd1000) && (out_pulse_width_us <= 11'd2000))
  `LSH_ASSERT_IMP(a_pulse_side, out_valid && (out_heading_deg > 16'sd0), out_pulse_width_us >= 11'd1500)

endmodule
